[sv/lp2c_pkg.sv]
// ----------------------------------------------------------------------------
// lp2c_pkg
// Shared types and constants for the polar-to-cartesian rotation pipeline.
// ----------------------------------------------------------------------------
package lp2c_pkg;

    // Field widths of a measurement and of a point
    localparam int ANGLE_W = 16;
    localparam int DIST_W  = 16;
    localparam int COORD_W = 17;

    // Vector datapath: Q24 fixed point, magnitude stays below 2^40
    localparam int FRAC_BITS = 24;
    localparam int XW        = 42;
    // Angle accumulator in 1/(64*65536) degree
    localparam int ZW        = 31;
    // Residual angle in 1/64 degree, range [-2880, 2879]
    localparam int RW        = 14;

    // Angle constants in 1/64 degree
    localparam logic [ANGLE_W-1:0] FULL_TURN    = 16'd23040;
    localparam logic [ANGLE_W-1:0] DOUBLE_TURN  = 16'd46080;
    localparam logic [14:0]        QUARTER_TURN = 15'd5760;
    localparam logic [14:0]        EIGHTH_TURN  = 15'd2880;

    // Output saturation bound
    localparam int OUT_LIMIT = 65535;

    // Gain compensation terms, Q30
    localparam longint GAIN_BASE = 64'd652032874;
    localparam longint GAIN_TAIL = 64'd434688583;
    localparam int     GAIN_W    = 30;

    // atan(2^-i) in accumulator units, rounded to nearest
    localparam int MAX_STAGES = 24;
    localparam logic signed [ZW-1:0] ATAN_TABLE [MAX_STAGES] = '{
        31'sd188743680, 31'sd111421900, 31'sd58872272, 31'sd29884485,
        31'sd15000234,  31'sd7507429,   31'sd3754631,  31'sd1877430,
        31'sd938729,    31'sd469366,    31'sd234683,   31'sd117342,
        31'sd58671,     31'sd29335,     31'sd14668,    31'sd7334,
        31'sd3667,      31'sd1833,      31'sd917,      31'sd458,
        31'sd229,       31'sd115,       31'sd57,       31'sd29
    };

    // Quadrant codes
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } lp2c_quad_t;

    // Data handed from one rotation cell to the next
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        lp2c_quad_t           quad;
    } lp2c_vec_t;

endpackage

[sv/lp2c_in_if.sv]
// ----------------------------------------------------------------------------
// lp2c_in_if
// Measurement channel: raw angle word and distance, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lp2c_in_if;

    logic                         valid;
    logic                         ready;
    logic [lp2c_pkg::ANGLE_W-1:0] raw_angle;
    logic [lp2c_pkg::DIST_W-1:0]  distance_quarter_mm;

    modport source (
        output valid,
        output raw_angle,
        output distance_quarter_mm,
        input  ready
    );

    modport sink (
        input  valid,
        input  raw_angle,
        input  distance_quarter_mm,
        output ready
    );

endinterface

[sv/lp2c_out_if.sv]
// ----------------------------------------------------------------------------
// lp2c_out_if
// Point channel: signed cartesian coordinates, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lp2c_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [lp2c_pkg::COORD_W-1:0] x_quarter_mm;
    logic signed [lp2c_pkg::COORD_W-1:0] y_quarter_mm;

    modport source (
        output valid,
        output x_quarter_mm,
        output y_quarter_mm,
        input  ready
    );

    modport sink (
        input  valid,
        input  x_quarter_mm,
        input  y_quarter_mm,
        output ready
    );

endinterface

[sv/lp2c_prep.sv]
// ----------------------------------------------------------------------------
// lp2c_prep
// Entry stage: wrap the angle, split it into quadrant and residual, and
// scale the distance by the gain compensation to form the start vector.
// ----------------------------------------------------------------------------
module lp2c_prep #(
    parameter int ANGLE_SHIFT     = 1,
    parameter int ROTATION_STAGES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lp2c_in_if.sink              meas,
    output logic                 dn_valid,
    output lp2c_pkg::lp2c_vec_t  dn_data,
    input  logic                 dn_ready
);
    import lp2c_pkg::*;

    localparam logic [GAIN_W-1:0] GAIN =
        GAIN_W'(GAIN_BASE + (GAIN_TAIL >> (2 * ROTATION_STAGES)));
    localparam int PROD_W = DIST_W + GAIN_W;

    logic                valid_reg;
    logic                valid_next;
    lp2c_vec_t           data_reg;
    lp2c_vec_t           data_next;

    logic [ANGLE_W-1:0]  ang_shift;
    logic [14:0]         ang;
    logic [14:0]         offset;
    lp2c_quad_t          quad;
    logic signed [RW-1:0] resid;
    logic [PROD_W-1:0]   prod;

    // Accept when this stage is empty or its content moves on
    assign meas.ready = !valid_reg || dn_ready;

    // Drop the check bit and wrap to one turn
    always_comb
    begin
        ang_shift = meas.raw_angle >> ANGLE_SHIFT;
        if (ang_shift >= DOUBLE_TURN)
        begin
            ang = 15'(ang_shift - DOUBLE_TURN);
        end
        else if (ang_shift >= FULL_TURN)
        begin
            ang = 15'(ang_shift - FULL_TURN);
        end
        else
        begin
            ang = 15'(ang_shift);
        end
    end

    // Pick the nearest quadrant; residual lands in [-45, 45) degrees
    always_comb
    begin
        if (ang < EIGHTH_TURN)
        begin
            quad   = QUAD_0;
            offset = 15'd0;
        end
        else if (ang < 15'(EIGHTH_TURN + QUARTER_TURN))
        begin
            quad   = QUAD_90;
            offset = QUARTER_TURN;
        end
        else if (ang < 15'(EIGHTH_TURN + 2 * QUARTER_TURN))
        begin
            quad   = QUAD_180;
            offset = 15'(2 * QUARTER_TURN);
        end
        else if (ang < 15'(EIGHTH_TURN + 3 * QUARTER_TURN))
        begin
            quad   = QUAD_270;
            offset = 15'(3 * QUARTER_TURN);
        end
        else
        begin
            quad   = QUAD_0;
            offset = 15'(FULL_TURN);
        end
        resid = RW'($signed({1'b0, ang}) - $signed({1'b0, offset}));
    end

    // Scale distance by the gain, keep Q24
    assign prod = PROD_W'(meas.distance_quarter_mm) * PROD_W'(GAIN);

    // Next stage content; a zero distance yields no point
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (meas.ready)
        begin
            valid_next     = meas.valid && (meas.distance_quarter_mm != '0);
            data_next.x    = XW'(prod >> (30 - FRAC_BITS));
            data_next.y    = '0;
            data_next.z    = {{(ZW - RW - 16){resid[RW-1]}}, resid, 16'd0};
            data_next.quad = quad;
        end
    end

    // Hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[sv/lp2c_cell.sv]
// ----------------------------------------------------------------------------
// lp2c_cell
// One rotation cell: a single micro-rotation by atan(2^-STAGE) with its own
// pipeline register and local flow control.
// ----------------------------------------------------------------------------
module lp2c_cell #(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  lp2c_pkg::lp2c_vec_t  up_data,
    output logic                 up_ready,
    output logic                 dn_valid,
    output lp2c_pkg::lp2c_vec_t  dn_data,
    input  logic                 dn_ready
);
    import lp2c_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = ATAN_TABLE[STAGE];

    logic                 valid_reg;
    logic                 valid_next;
    lp2c_vec_t            data_reg;
    lp2c_vec_t            data_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    // Take a new request when empty or when the content moves on
    assign up_ready = !valid_reg || dn_ready;

    // Floor shifts of both components
    assign xs = up_data.x >>> STAGE;
    assign ys = up_data.y >>> STAGE;

    // Rotate toward zero residual angle
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (up_ready)
        begin
            valid_next     = up_valid;
            data_next.quad = up_data.quad;
            if (!up_data.z[ZW-1])
            begin
                data_next.x = up_data.x - ys;
                data_next.y = up_data.y + xs;
                data_next.z = up_data.z - ATAN;
            end
            else
            begin
                data_next.x = up_data.x + ys;
                data_next.y = up_data.y - xs;
                data_next.z = up_data.z + ATAN;
            end
        end
    end

    // Hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

[sv/lp2c_post.sv]
// ----------------------------------------------------------------------------
// lp2c_post
// Exit stage: rotate by the quadrant, round Q24 to nearest, saturate, and
// hold the point in the output register.
// ----------------------------------------------------------------------------
module lp2c_post (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  lp2c_pkg::lp2c_vec_t  up_data,
    output logic                 up_ready,
    lp2c_out_if.source           point
);
    import lp2c_pkg::*;

    localparam int RND_W = XW - FRAC_BITS;
    localparam logic signed [XW-1:0]    HALF = XW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0] POS_LIMIT = RND_W'(OUT_LIMIT);
    localparam logic signed [RND_W-1:0] NEG_LIMIT = -RND_W'(OUT_LIMIT);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] x_next;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] y_next;

    logic signed [XW-1:0]      rx;
    logic signed [XW-1:0]      ry;
    logic signed [XW-1:0]      sum_x;
    logic signed [XW-1:0]      sum_y;
    logic signed [RND_W-1:0]   rnd_x;
    logic signed [RND_W-1:0]   rnd_y;
    logic signed [RND_W-1:0]   sat_x;
    logic signed [RND_W-1:0]   sat_y;

    assign up_ready = !valid_reg || point.ready;

    // Rotate by whole quarter turns
    always_comb
    begin
        case (up_data.quad)
            QUAD_90:
            begin
                rx = -up_data.y;
                ry = up_data.x;
            end
            QUAD_180:
            begin
                rx = -up_data.x;
                ry = -up_data.y;
            end
            QUAD_270:
            begin
                rx = up_data.y;
                ry = -up_data.x;
            end
            default:
            begin
                rx = up_data.x;
                ry = up_data.y;
            end
        endcase
    end

    // Round to nearest, floor after adding half
    always_comb
    begin
        sum_x = rx + HALF;
        sum_y = ry + HALF;
        rnd_x = sum_x[XW-1:FRAC_BITS];
        rnd_y = sum_y[XW-1:FRAC_BITS];
        sat_x = rnd_x;
        sat_y = rnd_y;
        if (rnd_x > POS_LIMIT)
        begin
            sat_x = POS_LIMIT;
        end
        else if (rnd_x < NEG_LIMIT)
        begin
            sat_x = NEG_LIMIT;
        end
        if (rnd_y > POS_LIMIT)
        begin
            sat_y = POS_LIMIT;
        end
        else if (rnd_y < NEG_LIMIT)
        begin
            sat_y = NEG_LIMIT;
        end
    end

    // Load the output register when it is free
    always_comb
    begin
        valid_next = valid_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
            x_next     = sat_x[COORD_W-1:0];
            y_next     = sat_y[COORD_W-1:0];
        end
    end

    // Hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign point.valid        = valid_reg;
    assign point.x_quarter_mm = x_reg;
    assign point.y_quarter_mm = y_reg;

endmodule

[sv/lidar_polar_to_cartesian_unit.sv]
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian_unit
// Converts range-finder measurements (angle word, distance) to cartesian
// points with a pipelined chain of CORDIC rotation cells.
//
//   Channel | Modport | Payload                              | Request
//   --------+---------+--------------------------------------+-------------
//   meas    | sink    | raw_angle, distance_quarter_mm       | measurement
//   point   | source  | x_quarter_mm, y_quarter_mm           | point
//
// One measurement enters per clock unless a stalled output has filled the
// pipeline; each passes one entry stage (angle wrap, gain multiply), one
// cell per rotation and one exit stage (quadrant, rounding, saturation).
// A zero distance is taken and produces no point.
// Reset clears every stage valid bit; the pipeline is empty afterwards.
// Each stage moves on when the next one is empty or moving, so a stalled
// point stops only the stages behind it and empty slots keep filling.
// ----------------------------------------------------------------------------
module lidar_polar_to_cartesian_unit #(
    parameter int ANGLE_SHIFT     = 1,
    parameter int ROTATION_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    lp2c_in_if.sink     meas,
    lp2c_out_if.source  point
);
    import lp2c_pkg::*;

    // Stage k output: 0 is the entry stage, k > 0 is rotation cell k - 1
    lp2c_vec_t stage_data  [ROTATION_STAGES + 1];
    logic      stage_valid [ROTATION_STAGES + 1];
    logic      stage_ready [ROTATION_STAGES + 1];

    // Entry stage
    lp2c_prep #(
        .ANGLE_SHIFT     (ANGLE_SHIFT),
        .ROTATION_STAGES (ROTATION_STAGES)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .meas     (meas),
        .dn_valid (stage_valid[0]),
        .dn_data  (stage_data[0]),
        .dn_ready (stage_ready[0])
    );

    // Chain of rotation cells
    for (genvar i = 0; i < ROTATION_STAGES; i++)
    begin : g_cell
        lp2c_cell #(
            .STAGE (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[i]),
            .up_data  (stage_data[i]),
            .up_ready (stage_ready[i]),
            .dn_valid (stage_valid[i + 1]),
            .dn_data  (stage_data[i + 1]),
            .dn_ready (stage_ready[i + 1])
        );
    end

    // Exit stage and output register
    lp2c_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stage_valid[ROTATION_STAGES]),
        .up_data  (stage_data[ROTATION_STAGES]),
        .up_ready (stage_ready[ROTATION_STAGES]),
        .point    (point)
    );

endmodule

[sim/tb_lidar_polar_to_cartesian_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lidar_polar_to_cartesian_unit
// Sends range-finder measurements through the rotation pipeline and checks
// every cartesian point against a fixed-point CORDIC predictor kept here.
// Covers cardinal and octant angles, angle wrap, the check bit, zero
// distance, random traffic under three idling mixes and a long output stall.
// ----------------------------------------------------------------------------
module tb_lidar_polar_to_cartesian_unit;

    import lp2c_pkg::*;

    localparam int ANGLE_SHIFT_P     = 1;
    localparam int ROT_STAGES        = 16;
    localparam int CLK_HALF          = 10;
    localparam int RESET_CYCLES      = 11;
    localparam int HOLD_CYCLES       = 300;
    localparam int STALL_LIMIT       = 2000;
    localparam int DRAIN_CYCLES      = ROT_STAGES + 40;
    localparam int RANDOM_PER_PHASE  = 135;

    // Angle arithmetic in 1/64 degree
    localparam longint TURN_UNITS    = 23040;
    localparam longint HALF_TURN     = 11520;
    localparam longint QUAD_UNITS    = 5760;
    localparam longint OCTANT_UNITS  = 2880;
    // Gain compensation, Q30
    localparam longint GAIN_Q30_MAIN = 64'sd652032874;
    localparam longint GAIN_Q30_TRIM = 64'sd434688583;
    localparam longint ROUND_HALF    = 64'sd8388608;
    localparam longint COORD_MAX     = 64'sd65535;

    // atan(2^-i) in 1/(64*65536) degree
    localparam longint ARCTAN_STEP [24] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    logic clk;
    logic rst_n;

    lp2c_in_if  meas_if ();
    lp2c_out_if point_if ();

    point_t pending_points [$];
    int     fail_count;
    int     stall_cycles;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_req;
    int     hold_count;

    lidar_polar_to_cartesian_unit #(
        .ANGLE_SHIFT     (ANGLE_SHIFT_P),
        .ROTATION_STAGES (ROT_STAGES)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .meas  (meas_if),
        .point (point_if)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Round a Q24 value to nearest and clamp to the coordinate range
    function automatic logic signed [COORD_W-1:0] round_to_coord(input longint v);
        longint r;
        r = (v + ROUND_HALF) >>> FRAC_BITS;
        if (r > COORD_MAX)
            r = COORD_MAX;
        if (r < -COORD_MAX)
            r = -COORD_MAX;
        return COORD_W'(r);
    endfunction

    // Predict the point for one measurement; returns 0 when none is produced
    function automatic bit predict_point(input logic [ANGLE_W-1:0] raw,
                                         input logic [DIST_W-1:0] dist_val,
                                         output point_t pt);
        longint     ang;
        longint     resid;
        longint     acc;
        longint     vx;
        longint     vy;
        longint     nx;
        longint     ny;
        longint     gain;
        lp2c_quad_t quad;
        int         i;
        pt.x = '0;
        pt.y = '0;
        if (dist_val == '0)
            return 1'b0;
        ang   = longint'(raw >> ANGLE_SHIFT_P) % TURN_UNITS;
        quad  = lp2c_quad_t'(2'(((ang + OCTANT_UNITS) / QUAD_UNITS) % 4));
        resid = ang - longint'(quad) * QUAD_UNITS;
        if (resid >= HALF_TURN)
            resid = resid - TURN_UNITS;
        acc  = resid * 65536;
        gain = GAIN_Q30_MAIN + (GAIN_Q30_TRIM >>> (2 * ROT_STAGES));
        vx   = (longint'(dist_val) * gain) >>> (GAIN_W - FRAC_BITS);
        vy   = 0;
        // Rotate toward zero residual angle
        for (i = 0; i < ROT_STAGES; i++)
        begin
            if (acc >= 0)
            begin
                nx  = vx - (vy >>> i);
                ny  = vy + (vx >>> i);
                acc = acc - ARCTAN_STEP[i];
            end
            else
            begin
                nx  = vx + (vy >>> i);
                ny  = vy - (vx >>> i);
                acc = acc + ARCTAN_STEP[i];
            end
            vx = nx;
            vy = ny;
        end
        // Apply the quadrant exactly
        case (quad)
            QUAD_90:
            begin
                nx = -vy;
                ny = vx;
            end
            QUAD_180:
            begin
                nx = -vx;
                ny = -vy;
            end
            QUAD_270:
            begin
                nx = vy;
                ny = -vx;
            end
            default:
            begin
                nx = vx;
                ny = vy;
            end
        endcase
        pt.x = round_to_coord(nx);
        pt.y = round_to_coord(ny);
        return 1'b1;
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_word(input int unsigned angle,
                                                      input bit chk);
        return ANGLE_W'((angle << ANGLE_SHIFT_P) | chk);
    endfunction

    // Offer one measurement request and record the expected point on accept
    task automatic send_measurement(input logic [ANGLE_W-1:0] raw,
                                    input logic [DIST_W-1:0] dist_val);
        point_t pt;
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            meas_if.valid = 1'b0;
            @(negedge clk);
        end
        meas_if.valid               = 1'b1;
        meas_if.raw_angle           = raw;
        meas_if.distance_quarter_mm = dist_val;
        do
            @(posedge clk);
        while (!meas_if.ready);
        if (predict_point(raw, dist_val, pt))
            pending_points.insert(pending_points.size(), pt);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        meas_if.valid = 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Quadrant centers, octant boundaries and field extremes
    task automatic test_cardinal_angles();
        send_measurement(angle_word(0, 1'b0), 16'hFFFF);
        send_measurement(angle_word(5760, 1'b1), 16'hFFFF);
        send_measurement(angle_word(11520, 1'b0), 16'hFFFF);
        send_measurement(angle_word(17280, 1'b1), 16'hFFFF);
        send_measurement(angle_word(2879, 1'b0), 16'hFFFF);
        send_measurement(angle_word(2880, 1'b1), 16'hFFFF);
        send_measurement(angle_word(8640, 1'b0), 16'hFFFF);
        send_measurement(angle_word(14400, 1'b1), 16'h8000);
        send_measurement(angle_word(20160, 1'b0), 16'h7FFF);
        send_measurement(angle_word(23039, 1'b1), 16'hFFFF);
        send_measurement(angle_word(1000, 1'b0), 16'd1);
        send_measurement(angle_word(13000, 1'b1), 16'd1);
        drop_valid();
    endtask

    // Zero distance produces no point, mixed with valid samples
    task automatic test_zero_distance();
        send_measurement(angle_word(0, 1'b0), 16'd0);
        send_measurement(angle_word(4000, 1'b1), 16'd2);
        send_measurement(16'hFFFF, 16'd0);
        send_measurement(angle_word(9000, 1'b0), 16'd0);
        send_measurement(angle_word(9000, 1'b0), 16'd3);
        drop_valid();
    endtask

    // Angles of a full turn or more wrap around
    task automatic test_angle_wrap();
        send_measurement(angle_word(23040, 1'b0), 16'd40000);
        send_measurement(angle_word(23040, 1'b1), 16'd40000);
        send_measurement(16'hFFFF, 16'hFFFF);
        send_measurement(16'hFFFE, 16'd12345);
        send_measurement(angle_word(28800, 1'b1), 16'd50000);
        drop_valid();
    endtask

    // Random measurements, weighted toward boundaries and edge distances
    task automatic test_random(input int count);
        logic [ANGLE_W-1:0] raw;
        logic [DIST_W-1:0]  dist_val;
        int unsigned        pick;
        int unsigned        base;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(9, 0);
            if (pick < 3)
            begin
                base = $urandom_range(7, 0) * 2880 + 23040;
                raw  = angle_word((base + $urandom_range(4, 0) - 2) % 23040,
                                  1'($urandom));
            end
            else if (pick < 4)
                raw = angle_word($urandom_range(32767, 23040), 1'($urandom));
            else
                raw = ANGLE_W'($urandom);
            pick = $urandom_range(9, 0);
            case (pick)
                0:       dist_val = '0;
                1:       dist_val = 16'hFFFF;
                2, 3, 4: dist_val = DIST_W'($urandom_range(255, 1));
                default: dist_val = DIST_W'($urandom_range(65535, 1));
            endcase
            send_measurement(raw, dist_val);
        end
        drop_valid();
    endtask

    // Hold off the output long enough for the pipeline to fill and stall
    task automatic test_backpressure();
        @(posedge clk);
        hold_req = 1'b1;
        for (int n = 0; n < 80; n++)
            send_measurement(ANGLE_W'($urandom), DIST_W'($urandom_range(65535, 1)));
        hold_req = 1'b0;
        drop_valid();
    endtask

    // Output ready: long hold-off when requested, random idling otherwise
    always @(negedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            point_if.ready = 1'b0;
            hold_count     = hold_count + 1;
        end
        else
        begin
            if (!hold_req)
                hold_count = 0;
            point_if.ready = !(recv_idle_pct != 0 &&
                               $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Compare each point with the oldest expectation
    always @(posedge clk)
    begin : point_check
        point_t want;
        if (rst_n && point_if.valid && point_if.ready)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected point, expected none, got x=%0d y=%0d",
                         $time, point_if.x_quarter_mm, point_if.y_quarter_mm);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_if.x_quarter_mm !== want.x)
                begin
                    $display("%0t: x_quarter_mm expected %0d, got %0d",
                             $time, want.x, point_if.x_quarter_mm);
                    fail_count = fail_count + 1;
                end
                if (point_if.y_quarter_mm !== want.y)
                begin
                    $display("%0t: y_quarter_mm expected %0d, got %0d",
                             $time, want.y, point_if.y_quarter_mm);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Watchdog: abort when no request moves on either side for too long
    always @(posedge clk)
    begin
        if ((meas_if.valid && meas_if.ready) || (point_if.valid && point_if.ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        fail_count                  = 0;
        stall_cycles                = 0;
        hold_req                    = 1'b0;
        hold_count                  = 0;
        send_idle_pct               = 0;
        recv_idle_pct               = 0;
        rst_n                       = 1'b0;
        meas_if.valid               = 1'b0;
        meas_if.raw_angle           = '0;
        meas_if.distance_quarter_mm = '0;
        point_if.ready              = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        set_idling(31, 84);
        test_cardinal_angles();
        test_zero_distance();
        test_angle_wrap();
        test_random(RANDOM_PER_PHASE);

        set_idling(84, 31);
        test_random(RANDOM_PER_PHASE);

        set_idling(0, 0);
        test_backpressure();
        test_random(RANDOM_PER_PHASE);

        // Drain and let any stray point show up
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[lidar_polar_to_cartesian_unit.f]
sv/lp2c_pkg.sv
sv/lp2c_in_if.sv
sv/lp2c_out_if.sv
sv/lp2c_prep.sv
sv/lp2c_cell.sv
sv/lp2c_post.sv
sv/lidar_polar_to_cartesian_unit.sv
sim/tb_lidar_polar_to_cartesian_unit.sv
